// ----- src/sleb128_delta_decoder_assert.svh -----
// Assertion macros used by the decoder top level.
`ifndef SLEB128_DELTA_DECODER_ASSERT_SVH
`define SLEB128_DELTA_DECODER_ASSERT_SVH

`ifndef SYNTHESIS

`define SLEB_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");

`define SLEB_ASSERT_RST(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`else

`define SLEB_ASSERT_CLK(label, clk, rst_n, prop)

`define SLEB_ASSERT_RST(label, clk, prop)

`endif

`endif

// ----- src/sleb_pkg.sv -----
// Types and constants of the SLEB128 delta decoder.
package sleb_pkg;

    localparam int OUT_W   = 64;
    localparam int GROUP_W = 7;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_TRUNC    = 2'd1,
        STATUS_OVERLONG = 2'd2
    } status_t;

    typedef struct packed {
        logic               has_result;
        status_t            status;
        logic               last_beat;
        logic [OUT_W-1:0]   delta;
        logic [OUT_W-1:0]   running;
    } result_t;

endpackage

// ----- src/sleb_decode.sv -----
// Combinational step of the decoder: folds one byte into the open value and the sum.
module sleb_decode #(
    parameter int VALUE_WIDTH = 64,
    parameter int BIT_POS_W   = 7
) (
    input  logic [VALUE_WIDTH-1:0] partial_in,
    input  logic [BIT_POS_W-1:0]   bitpos_in,
    input  logic [VALUE_WIDTH-1:0] sum_in,
    input  logic                   overlong_in,
    input  logic [7:0]             data_byte,
    input  logic                   buffer_end,
    output logic [VALUE_WIDTH-1:0] partial_out,
    output logic [BIT_POS_W-1:0]   bitpos_out,
    output logic [VALUE_WIDTH-1:0] sum_out,
    output logic                   overlong_out,
    output sleb_pkg::result_t      result
);
    import sleb_pkg::*;

    localparam logic [BIT_POS_W-1:0] WIDTH_POS = BIT_POS_W'(VALUE_WIDTH);
    localparam logic [BIT_POS_W-1:0] GROUP_POS = BIT_POS_W'(GROUP_W);

    logic                   in_range;
    logic                   cont;
    logic [VALUE_WIDTH-1:0] group_ext;
    logic [VALUE_WIDTH-1:0] partial_new;
    logic [BIT_POS_W-1:0]   bitpos_new;
    logic                   overlong_new;
    logic [VALUE_WIDTH-1:0] value;
    logic [VALUE_WIDTH-1:0] sum_new;

    assign in_range     = bitpos_in < WIDTH_POS;
    assign cont         = data_byte[7];
    assign group_ext    = {{(VALUE_WIDTH-GROUP_W){1'b0}}, data_byte[GROUP_W-1:0]};
    assign partial_new  = in_range ? (partial_in | (group_ext << bitpos_in)) : partial_in;
    assign bitpos_new   = in_range ? (bitpos_in + GROUP_POS) : bitpos_in;
    assign overlong_new = overlong_in | ~in_range;

    always_comb begin
        value = partial_new;
        if ((bitpos_new < WIDTH_POS) && data_byte[6]) begin
            value = partial_new | ({VALUE_WIDTH{1'b1}} << bitpos_new);
        end
    end

    assign sum_new = sum_in + value;

    always_comb begin
        result.has_result = ~cont | buffer_end;
        result.last_beat  = buffer_end;
        if (cont) begin
            result.status  = STATUS_TRUNC;
            result.delta   = '0;
            result.running = OUT_W'(signed'(sum_in));
        end else begin
            result.status  = overlong_new ? STATUS_OVERLONG : STATUS_OK;
            result.delta   = OUT_W'(signed'(value));
            result.running = OUT_W'(signed'(sum_new));
        end

        if (buffer_end) begin
            partial_out  = '0;
            bitpos_out   = '0;
            sum_out      = '0;
            overlong_out = 1'b0;
        end else if (!cont) begin
            partial_out  = '0;
            bitpos_out   = '0;
            sum_out      = sum_new;
            overlong_out = 1'b0;
        end else begin
            partial_out  = partial_new;
            bitpos_out   = bitpos_new;
            sum_out      = sum_in;
            overlong_out = overlong_new;
        end
    end

endmodule

// ----- src/sleb128_delta_decoder.sv -----
// Top level of the SLEB128 delta decoder: input register, decode step, result register.
//
//   Channel | Ports                                          | Carries
//   s_      | s_valid s_ready s_data_byte s_buffer_end       | one encoded byte per beat
//   m_      | m_valid m_ready m_decoded_delta m_running_value | one decoded value per beat
//           | m_status_code m_final_of_buffer                |
//
// One byte is taken every cycle unless a stalled result holds it; the byte that ends a value
// passes the input register and then the decode step, which sits before the result register.
// Reset is synchronous and active low and clears the decode state and both valid flags.
// A stalled result holds only bytes that end a value or the buffer; continuation bytes keep flowing.
`include "sleb128_delta_decoder_assert.svh"

module sleb128_delta_decoder #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_buffer_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic signed [sleb_pkg::OUT_W-1:0] m_decoded_delta,
    output logic signed [sleb_pkg::OUT_W-1:0] m_running_value,
    output logic [1:0]  m_status_code,
    output logic        m_final_of_buffer
);
    import sleb_pkg::*;

    localparam int BIT_POS_W = $clog2(VALUE_WIDTH + GROUP_W);

    logic                   in_valid_reg;
    logic [7:0]             byte_reg;
    logic                   last_reg;

    logic [VALUE_WIDTH-1:0] partial_reg, partial_next;
    logic [BIT_POS_W-1:0]   bitpos_reg, bitpos_next;
    logic [VALUE_WIDTH-1:0] sum_reg, sum_next;
    logic                   overlong_reg, overlong_next;

    result_t                result;
    result_t                out_reg;
    logic                   out_valid_reg;

    logic                   out_free;
    logic                   advance;

    sleb_decode #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .BIT_POS_W   (BIT_POS_W)
    ) u_decode (
        .partial_in   (partial_reg),
        .bitpos_in    (bitpos_reg),
        .sum_in       (sum_reg),
        .overlong_in  (overlong_reg),
        .data_byte    (byte_reg),
        .buffer_end   (last_reg),
        .partial_out  (partial_next),
        .bitpos_out   (bitpos_next),
        .sum_out      (sum_next),
        .overlong_out (overlong_next),
        .result       (result)
    );

    assign out_free = ~out_valid_reg | m_ready;
    assign advance  = in_valid_reg & (~result.has_result | out_free);
    assign s_ready  = ~in_valid_reg | advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            byte_reg <= s_data_byte;
            last_reg <= s_buffer_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            partial_reg  <= '0;
            bitpos_reg   <= '0;
            sum_reg      <= '0;
            overlong_reg <= 1'b0;
        end else if (advance) begin
            partial_reg  <= partial_next;
            bitpos_reg   <= bitpos_next;
            sum_reg      <= sum_next;
            overlong_reg <= overlong_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && result.has_result) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && result.has_result) begin
            out_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_decoded_delta   = out_reg.delta;
    assign m_running_value   = out_reg.running;
    assign m_status_code     = out_reg.status;
    assign m_final_of_buffer = out_reg.last_beat;

    `SLEB_ASSERT_RST(a_reset_clears_valid, aclk, !aresetn |=> (!m_valid && !in_valid_reg))
    `SLEB_ASSERT_CLK(a_bitpos_bound, aclk, aresetn, bitpos_reg <= BIT_POS_W'(VALUE_WIDTH + 6))
    `SLEB_ASSERT_CLK(a_overlong_needs_width, aclk, aresetn, overlong_reg |-> bitpos_reg >= BIT_POS_W'(VALUE_WIDTH))
    `SLEB_ASSERT_CLK(a_buffer_end_clears, aclk, aresetn, (advance && last_reg) |=> (sum_reg == '0 && bitpos_reg == '0 && !overlong_reg))
    `SLEB_ASSERT_CLK(a_trunc_shape, aclk, aresetn, (m_valid && m_status_code == STATUS_TRUNC) |-> (m_decoded_delta == '0 && m_final_of_buffer))

endmodule
